[src/ser_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ser_pkg;

  localparam int unsigned SegmentSlots = 1024;
  localparam int unsigned IdxW         = $clog2(SegmentSlots);
  localparam int unsigned CntW         = IdxW + 1;
  localparam int unsigned SectorShift  = 11;   // 2048-byte sectors
  localparam int unsigned MaxChunks    = 64;
  localparam int unsigned ChunkCntW    = 7;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PAST_END  = 3'd1,
    ST_GAP       = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_CONT  = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_e;

  localparam logic [1:0] KindMem  = 2'd0;
  localparam logic [1:0] KindFile = 2'd1;
  localparam logic [1:0] KindZero = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [32:0] sector_address;
    logic [32:0] sector_count;
    logic [31:0] source_start;
    logic [31:0] content_length;
    logic [1:0]  extent_kind;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  chunk_kind;
    logic [9:0]  segment_index;
    logic [31:0] offset_in_segment;
    logic [32:0] source_read_sector;
    logic [31:0] chunk_sectors;
    logic [31:0] kept_bytes;
    logic        last;
  } rsp_t;

endpackage
`default_nettype wire

[src/sector_extent_remap.sv]
`timescale 1ns / 1ps
`default_nettype none
// clear and load: result beat the cycle after the input beat, next input beat the cycle after
//   the result beat is taken
// read: every chunk runs a fresh binary search of at most log2(count)+1 steps (11 for a full
//   table), each S_SCMP, S_SRD, S_CWAIT, then S_CHK to S_EMIT; S_IDLE after each taken beat
// reset clears the extent count and the expected start; the table is not cleared
module sector_extent_remap (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ser_pkg::req_t in_data_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output ser_pkg::rsp_t      out_data_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i
);
  import ser_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SRD    = 9'b000000010,  // memory read issued
    S_SCMP   = 9'b000000100,  // issue search read, or finish the search
    S_CHK    = 9'b000001000,  // read found extent
    S_CWAIT  = 9'b000010000,  // compare end against current
    S_CALC   = 9'b000100000,  // chunk size
    S_BYTES  = 9'b001000000,  // valid bytes
    S_EMIT   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  typedef struct packed {
    logic [32:0] start;
    logic [32:0] length;
    logic [31:0] source;
    logic [31:0] content;
    logic [1:0]  kind;
  } ext_t;

  ext_t ext_mem [SegmentSlots];
  ext_t rd_q;

  state_e      state_q;
  logic [CntW-1:0] count_q;
  logic [33:0] next_start_q;
  logic        cont_q;       // read still in progress after an output
  logic [33:0] cur_q;
  logic [32:0] rem_q;
  logic [CntW-1:0] first_q, span_q;
  logic [IdxW-1:0] rd_addr_q;
  logic [ChunkCntW-1:0] nchunk_q;
  logic [32:0] within_q;
  logic [31:0] chunk_q;
  rsp_t        out_q;
  logic        out_valid_q;

  logic [CntW-1:0] half, mid;
  assign half = span_q >> 1;
  assign mid  = first_q + half;

  logic wr_en;
  ext_t wr_data;
  assign wr_en = (state_q == S_IDLE) && in_valid_i && in_ready_o &&
                 (in_data_i.command == CMD_LOAD) && (count_q < CntW'(SegmentSlots)) &&
                 ({1'b0, in_data_i.sector_address} == next_start_q);
  always_comb begin
    wr_data.start   = in_data_i.sector_address;
    wr_data.length  = in_data_i.sector_count;
    wr_data.source  = in_data_i.source_start;
    wr_data.content = in_data_i.content_length;
    wr_data.kind    = (in_data_i.extent_kind == 2'd3) ? KindZero : in_data_i.extent_kind;
  end

  // extent memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ext_mem[count_q[IdxW-1:0]] <= wr_data;
    end
    rd_q <= ext_mem[rd_addr_q];
  end

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q && !cont_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status-only beat for clear, load and stopped reads
  status_e stat_code;
  rsp_t    stat_rsp;
  always_comb begin
    stat_code = ST_OK;
    if (state_q == S_SCMP) begin
      stat_code = ST_PAST_END;
    end else if (state_q == S_CWAIT) begin
      stat_code = ST_GAP;
    end else if (in_data_i.command == CMD_LOAD) begin
      if (count_q >= CntW'(SegmentSlots)) begin
        stat_code = ST_FULL;
      end else if ({1'b0, in_data_i.sector_address} != next_start_q) begin
        stat_code = ST_NOT_CONT;
      end
    end
  end
  always_comb begin
    stat_rsp        = '0;
    stat_rsp.status = stat_code;
    stat_rsp.last   = 1'b1;
  end

  // chunk arithmetic, one step per state
  logic [33:0] ext_end;
  logic [32:0] avail, chunk_w;
  logic [43:0] coff, cbytes;
  logic [43:0] valid_w;
  assign ext_end = {1'b0, rd_q.start} + {1'b0, rd_q.length};
  assign avail   = rd_q.length - within_q;
  always_comb begin
    chunk_w = (avail < rem_q) ? avail : rem_q;
    if (chunk_w > 33'hFFFFFFFF) chunk_w = 33'hFFFFFFFF;
  end
  assign coff   = {within_q, 11'd0};
  assign cbytes = {1'b0, chunk_q, 11'd0};
  always_comb begin
    valid_w = ({12'd0, rd_q.content} > coff) ? ({12'd0, rd_q.content} - coff) : '0;
    if (valid_w > cbytes) valid_w = cbytes;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      next_start_q <= '0;
      out_valid_q  <= 1'b0;
      cont_q       <= 1'b0;
      rd_addr_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            case (in_data_i.command)
              CMD_CLEAR: begin
                out_q        <= stat_rsp;
                count_q      <= '0;
                next_start_q <= '0;
                out_valid_q  <= 1'b1;
              end
              CMD_LOAD: begin
                out_q <= stat_rsp;
                if (wr_en) begin
                  count_q      <= count_q + CntW'(1);
                  next_start_q <= next_start_q + {1'b0, in_data_i.sector_count};
                end
                out_valid_q <= 1'b1;
              end
              CMD_READ: begin
                if (in_data_i.sector_count != '0) begin
                  cur_q    <= {1'b0, in_data_i.sector_address};
                  rem_q    <= in_data_i.sector_count;
                  nchunk_q <= '0;
                  first_q  <= '0;
                  span_q   <= count_q;
                  state_q  <= S_SCMP;
                  cont_q   <= 1'b1;
                end
              end
              default: ;
            endcase
          end else if (cont_q && !out_valid_q) begin
            first_q <= '0;
            span_q  <= count_q;
            state_q <= S_SCMP;
          end
        end
        S_SCMP: begin
          // search step: issue read of mid, or finish
          if (span_q == '0) begin
            if (first_q >= count_q) begin
              out_q   <= stat_rsp;
              state_q <= S_OUT;
            end else begin
              rd_addr_q <= first_q[IdxW-1:0];
              state_q   <= S_CHK;
            end
          end else begin
            rd_addr_q <= mid[IdxW-1:0];
            state_q   <= S_SRD;
          end
        end
        S_SRD: state_q <= S_CWAIT;
        S_CHK: state_q <= S_CWAIT;
        S_CWAIT: begin
          if (span_q != '0) begin
            // rd_q holds mid entry
            if (ext_end <= cur_q) begin
              first_q <= mid + CntW'(1);
              span_q  <= span_q - half - CntW'(1);
            end else begin
              span_q <= half;
            end
            state_q <= S_SCMP;
          end else if (cur_q < {1'b0, rd_q.start}) begin
            out_q   <= stat_rsp;
            state_q <= S_OUT;
          end else begin
            within_q <= 33'(cur_q - {1'b0, rd_q.start});
            state_q  <= S_CALC;
          end
        end
        S_CALC: begin
          chunk_q <= chunk_w[31:0];
          state_q <= S_BYTES;
        end
        S_BYTES: begin
          out_q.kept_bytes         <= (rd_q.kind == KindFile) ? valid_w[31:0] : '0;
          out_q.source_read_sector <= (rd_q.kind == KindFile) ?
                                      ({1'b0, rd_q.source} + within_q) : '0;
          out_q.chunk_kind         <= rd_q.kind;
          out_q.segment_index      <= 10'(first_q);
          out_q.offset_in_segment  <= within_q[31:0];
          out_q.chunk_sectors      <= chunk_q;
          cur_q   <= cur_q + {2'b0, chunk_q};
          rem_q   <= rem_q - {1'b0, chunk_q};
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          out_q.status <= (rem_q != '0 && nchunk_q == ChunkCntW'(MaxChunks - 1)) ?
                          ST_TRUNCATED : ST_OK;
          out_q.last   <= (rem_q == '0) || (nchunk_q == ChunkCntW'(MaxChunks - 1));
          nchunk_q     <= nchunk_q + ChunkCntW'(1);
          out_valid_q  <= 1'b1;
          cont_q       <= !((rem_q == '0) || (nchunk_q == ChunkCntW'(MaxChunks - 1)));
          state_q      <= S_IDLE;
        end
        S_OUT: begin
          out_valid_q <= 1'b1;
          cont_q      <= 1'b0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[dv/tb_sector_extent_remap.sv]
`timescale 1ns / 1ps
module tb_sector_extent_remap;
  import ser_pkg::*;

  localparam int unsigned StallLimit   = 20000;
  localparam int unsigned TruncExtents = 70;
  localparam logic [32:0] Max33        = 33'h1_FFFF_FFFF;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  req_t  in_data = '0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  rsp_t  out_data;
  logic  out_valid;
  logic  out_ready = 1'b0;

  sector_extent_remap DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .out_data_o  (out_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the extent table
  logic [32:0] map_start [SegmentSlots];
  logic [32:0] map_len [SegmentSlots];
  logic [31:0] map_src [SegmentSlots];
  logic [31:0] map_content [SegmentSlots];
  logic [1:0]  map_kind [SegmentSlots];
  int unsigned map_count = 0;
  logic [33:0] next_start = '0;

  rsp_t        chunk_q[$];
  int unsigned errors = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned reads_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned quiet_cycles = 0;

  function automatic rsp_t mk_chunk(status_e st, logic [1:0] k, logic [9:0] idx,
                                    logic [31:0] off, logic [32:0] srd,
                                    logic [31:0] secs, logic [31:0] vb, logic lst);
    rsp_t r;
    r.status             = st;
    r.chunk_kind         = k;
    r.segment_index      = idx;
    r.offset_in_segment  = off;
    r.source_read_sector = srd;
    r.chunk_sectors      = secs;
    r.kept_bytes         = vb;
    r.last               = lst;
    return r;
  endfunction

  // first extent whose end lies beyond the sector
  function automatic int unsigned find_extent(logic [63:0] sector);
    int unsigned first, count, half, mid;
    first = 0;
    count = map_count;
    while (count != 0) begin
      half = count / 2;
      mid  = first + half;
      if ({31'b0, map_start[mid]} + {31'b0, map_len[mid]} <= sector) begin
        first = mid + 1;
        count -= half + 1;
      end else begin
        count = half;
      end
    end
    return first;
  endfunction

  // update the shadow table and queue the chunks an accepted beat causes
  function automatic void remap_predict(req_t r);
    logic [63:0] cur, rem, seg_off, avail, chunk, coff, cbytes, vb, srd;
    int unsigned idx, n;
    status_e     st;
    case (cmd_e'(r.command))
      CMD_CLEAR: begin
        map_count  = 0;
        next_start = '0;
        chunk_q.push_back(mk_chunk(ST_OK, 0, 0, 0, 0, 0, 0, 1'b1));
      end
      CMD_LOAD: begin
        st = ST_OK;
        if (map_count >= SegmentSlots) st = ST_FULL;
        else if ({1'b0, r.sector_address} != next_start) st = ST_NOT_CONT;
        else begin
          map_start[map_count]   = r.sector_address;
          map_len[map_count]     = r.sector_count;
          map_src[map_count]     = r.source_start;
          map_content[map_count] = r.content_length;
          map_kind[map_count]    = (r.extent_kind == 2'd3) ? KindZero : r.extent_kind;
          map_count++;
          next_start = next_start + {1'b0, r.sector_count};
        end
        chunk_q.push_back(mk_chunk(st, 0, 0, 0, 0, 0, 0, 1'b1));
      end
      CMD_READ: begin
        cur = {31'b0, r.sector_address};
        rem = {31'b0, r.sector_count};
        n   = 0;
        while (rem != 0 && n < MaxChunks) begin
          idx = find_extent(cur);
          if (idx >= map_count) begin
            chunk_q.push_back(mk_chunk(ST_PAST_END, 0, 0, 0, 0, 0, 0, 1'b1));
            return;
          end
          if (cur < {31'b0, map_start[idx]}) begin
            chunk_q.push_back(mk_chunk(ST_GAP, 0, 0, 0, 0, 0, 0, 1'b1));
            return;
          end
          seg_off = cur - {31'b0, map_start[idx]};
          avail   = {31'b0, map_len[idx]} - seg_off;
          chunk   = (avail < rem) ? avail : rem;
          if (chunk > 64'hFFFF_FFFF) chunk = 64'hFFFF_FFFF;
          vb  = 0;
          srd = 0;
          if (map_kind[idx] == KindFile) begin
            coff   = seg_off << SectorShift;
            cbytes = chunk << SectorShift;
            vb     = ({32'b0, map_content[idx]} > coff) ? {32'b0, map_content[idx]} - coff : 0;
            if (vb > cbytes) vb = cbytes;
            srd = {32'b0, map_src[idx]} + seg_off;
          end
          cur += chunk;
          rem -= chunk;
          st = (rem != 0 && n + 1 == MaxChunks) ? ST_TRUNCATED : ST_OK;
          chunk_q.push_back(mk_chunk(st, map_kind[idx], idx[9:0], seg_off[31:0],
                                     srd[32:0], chunk[31:0], vb[31:0],
                                     rem == 0 || n + 1 == MaxChunks));
          n++;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, field, got, want);
    errors++;
  endtask

  // result beat checker
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid && out_ready) begin
      beats_out++;
      if (chunk_q.size() == 0) begin
        report("unexpected beat", 64'(out_data.chunk_sectors), 64'd0);
      end else begin
        want = chunk_q.pop_front();
        if (out_data.status != want.status)
          report("status", 64'(out_data.status), 64'(want.status));
        if (out_data.chunk_kind != want.chunk_kind)
          report("chunk_kind", 64'(out_data.chunk_kind), 64'(want.chunk_kind));
        if (out_data.segment_index != want.segment_index)
          report("segment_index", 64'(out_data.segment_index), 64'(want.segment_index));
        if (out_data.offset_in_segment != want.offset_in_segment)
          report("offset_in_segment", 64'(out_data.offset_in_segment),
                 64'(want.offset_in_segment));
        if (out_data.source_read_sector != want.source_read_sector)
          report("source_read_sector", 64'(out_data.source_read_sector),
                 64'(want.source_read_sector));
        if (out_data.chunk_sectors != want.chunk_sectors)
          report("chunk_sectors", 64'(out_data.chunk_sectors), 64'(want.chunk_sectors));
        if (out_data.kept_bytes != want.kept_bytes)
          report("kept_bytes", 64'(out_data.kept_bytes), 64'(want.kept_bytes));
        if (out_data.last != want.last) report("last", 64'(out_data.last), 64'(want.last));
      end
    end
  end

  // receiver stalls and the long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("timeout: no beat for %0d cycles", StallLimit);
      $display("tb_sector_extent_remap: FAIL");
      $finish;
    end
  end

  task automatic send_item(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk_i); while (!in_ready);
    remap_predict(r);
    beats_in++;
    if (r.command == CMD_READ) reads_sent++;
  endtask

  task automatic send_cmd(cmd_e c, logic [32:0] addr, logic [32:0] cnt,
                          logic [31:0] src, logic [31:0] content, logic [1:0] k);
    req_t r;
    r.command        = c;
    r.sector_address = addr;
    r.sector_count   = cnt;
    r.source_start   = src;
    r.content_length = content;
    r.extent_kind    = k;
    send_item(r);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (chunk_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // field extremes, every command, odd kinds, wide spans
  task automatic test_directed();
    send_cmd(CMD_READ, 0, 5, 0, 0, KindMem);
    send_cmd(CMD_READ, 0, 0, 0, 0, KindMem);
    send_cmd(CMD_LOAD, 0, 10, 32'd100, 32'd5000, KindFile);
    send_cmd(CMD_LOAD, 33'd11, 4, 0, 0, KindMem);
    send_cmd(CMD_LOAD, 33'd10, 0, 0, 0, KindMem);
    send_cmd(CMD_LOAD, 33'd10, 6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    send_cmd(CMD_LOAD, 33'd16, 3, 0, 0, KindZero);
    send_cmd(CMD_NONE, Max33, Max33, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    send_cmd(CMD_READ, 33'd2, 16, 0, 0, KindMem);
    send_cmd(CMD_READ, 33'd18, 5, 0, 0, KindMem);
    send_cmd(CMD_READ, 33'd19, 1, 0, 0, KindMem);
    send_cmd(CMD_READ, Max33, Max33, 0, 0, KindMem);
    send_cmd(CMD_CLEAR, Max33, Max33, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    send_cmd(CMD_LOAD, 0, Max33, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KindFile);
    send_cmd(CMD_LOAD, Max33, 33'd5, 32'd7, 32'd1, KindFile);
    send_cmd(CMD_READ, 0, Max33, 0, 0, KindMem);
    send_cmd(CMD_READ, 33'd3, 33'h1_0000_0000, 0, 0, KindMem);
    send_cmd(CMD_READ, Max33 - 2, 33'd10, 0, 0, KindMem);
    send_cmd(CMD_LOAD, 33'd5, 1, 0, 0, KindMem);
    drain();
  endtask

  // more extents than one read may cross, then reads at and past the chunk limit
  task automatic test_truncation();
    send_cmd(CMD_CLEAR, 0, 0, 0, 0, KindMem);
    for (int i = 0; i < TruncExtents; i++)
      send_cmd(CMD_LOAD, 33'(i), 33'd1, $urandom, 32'($urandom_range(4096)),
               2'($urandom_range(3)));
    send_cmd(CMD_LOAD, 33'(TruncExtents + 1), 33'd1, 0, 0, KindMem);
    send_cmd(CMD_READ, 0, 33'd200, 0, 0, KindMem);
    send_cmd(CMD_READ, 33'd4, 33'd64, 0, 0, KindMem);
    send_cmd(CMD_READ, 33'd30, 33'd50, 0, 0, KindMem);
    send_cmd(CMD_READ, 33'(TruncExtents - 1), 33'd1, 0, 0, KindMem);
    drain();
  endtask

  // well-formed sessions with random content, plus noise
  task automatic random_session();
    int unsigned n_ext, n_rd;
    logic [32:0] len, addr, cnt;
    send_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom_range(3));
    n_ext = $urandom_range(1, 10);
    for (int i = 0; i < n_ext; i++) begin
      case ($urandom_range(9))
        0:       len = 0;
        1:       len = {$urandom_range(1), $urandom};
        2:       len = $urandom_range(100, 70000);
        default: len = $urandom_range(1, 12);
      endcase
      if ($urandom_range(9) == 0)
        send_cmd(CMD_LOAD, {$urandom_range(1), $urandom}, len, $urandom, $urandom,
                 $urandom_range(3));
      else
        send_cmd(CMD_LOAD, next_start[32:0], len, $urandom, $urandom,
                 $urandom_range(3));
    end
    n_rd = $urandom_range(1, 4);
    for (int i = 0; i < n_rd; i++) begin
      case ($urandom_range(7))
        0:       addr = {$urandom_range(1), $urandom};
        1:       addr = next_start[32:0] + $urandom_range(3);
        default: addr = {$urandom_range(1), $urandom} % (next_start[32:0] + 1);
      endcase
      case ($urandom_range(7))
        0:       cnt = {$urandom_range(1), $urandom};
        1:       cnt = 0;
        default: cnt = $urandom_range(1, 40);
      endcase
      if ($urandom_range(15) == 0)
        send_cmd(CMD_NONE, addr, cnt, $urandom, $urandom, $urandom_range(3));
      send_cmd(CMD_READ, addr, cnt, $urandom, $urandom, $urandom_range(3));
    end
  endtask

  task automatic test_random(int unsigned idle, int unsigned stall, int unsigned items);
    int unsigned stop_at;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = beats_in + items;
    while (beats_in < stop_at) random_session();
    drain();
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    send_cmd(CMD_CLEAR, 0, 0, 0, 0, KindMem);
    for (int i = 0; i < 8; i++) send_cmd(CMD_LOAD, 2 * i, 2, $urandom, $urandom, KindFile);
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) send_cmd(CMD_READ, $urandom_range(15), 33'd4, 0, 0, KindMem);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_truncation();
    test_backpressure();
    test_random(0, 0, 30);
    test_random(49, 0, 30);
    test_random(0, 49, 30);
    test_random(19, 19, 30);
    $display("covered %0d input beats (%0d reads) and %0d result beats", beats_in,
             reads_sent, beats_out);
    $display("directed edges, chunk limit, hold-off and four idle mixes");
    if (errors == 0) begin
      $display("tb_sector_extent_remap: PASS");
    end else begin
      $display("tb_sector_extent_remap: FAIL");
    end
    $finish;
  end

endmodule
